// ===== rtl/methylation_pileup_table_defines.svh =====
`ifndef METHYLATION_PILEUP_TABLE_DEFINES_SVH
`define METHYLATION_PILEUP_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define MPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mpt_pkg.sv =====
package mpt_pkg;

  localparam int TABLE_DEPTH = 2048;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic {
    OP_COUNT = 1'b0,
    OP_FLUSH = 1'b1
  } op_kind_e;

  typedef enum logic [1:0] {
    CNT_NONE   = 2'd0,
    CNT_METH   = 2'd1,
    CNT_UNMETH = 2'd2
  } cnt_kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_EXEC  = 2'd2
  } back_state_e;

  typedef struct packed {
    op_kind_e         kind;
    logic [IDX_W-1:0] idx;
    logic [31:0]      pos;
    logic [9:0]       chrom;
    logic             minus;
    logic             cpg;
    cnt_kind_e        cnt;
  } op_t;

  typedef struct packed {
    logic             valid;
    logic [31:0]      pos;
    logic [9:0]       chrom;
    logic             minus;
    logic             cpg;
    logic [CNT_W-1:0] meth;
    logic [CNT_W-1:0] unmeth;
  } entry_t;

  typedef struct packed {
    logic             is_cpg;
    logic [CNT_W-1:0] meth_count;
    logic [CNT_W:0]   total_count;
    logic             site_minus;
    logic [9:0]       site_chrom;
    logic [31:0]      site_position;
  } site_t;

endpackage

// ===== rtl/mpt_front.sv =====
module mpt_front import mpt_pkg::*; (
  input  logic        in_valid_i,
  input  logic        in_cmd_i,
  input  logic [79:0] in_data_i,
  input  logic        q_ready_i,
  input  logic        clearing_i,
  output logic        in_ready_o,
  output logic        q_push_o,
  output op_t         q_op_o
);

  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_G  = 8'h47;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7a;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CH_LA && c <= CH_LZ) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  logic [10:0] slot;
  logic [31:0] pos;
  logic [9:0]  chrom;
  logic        minus;
  logic [7:0]  ref_f, rd_f, ctx_f;
  logic [7:0]  meth_b, unmeth_b, cpg_b;
  logic        keep;

  assign slot  = in_data_i[10:0];
  assign pos   = in_data_i[42:11];
  assign chrom = in_data_i[52:43];
  assign minus = in_data_i[53];
  assign ref_f = fold(in_data_i[61:54]);
  assign rd_f  = fold(in_data_i[69:62]);
  assign ctx_f = fold(in_data_i[77:70]);

  assign meth_b   = minus ? CH_G : CH_C;
  assign unmeth_b = minus ? CH_A : CH_T;
  assign cpg_b    = minus ? CH_C : CH_G;

  always_comb begin
    q_op_o.pos   = pos;
    q_op_o.chrom = chrom;
    q_op_o.minus = minus;
    q_op_o.cpg   = (ctx_f == cpg_b);
    if (rd_f == meth_b) begin
      q_op_o.cnt = CNT_METH;
    end else if (rd_f == unmeth_b) begin
      q_op_o.cnt = CNT_UNMETH;
    end else begin
      q_op_o.cnt = CNT_NONE;
    end
    if (in_cmd_i) begin
      q_op_o.kind = OP_FLUSH;
      q_op_o.idx  = IDX_W'(slot);
      keep        = (32'(slot) < 32'(TABLE_DEPTH));
    end else begin
      q_op_o.kind = OP_COUNT;
      q_op_o.idx  = IDX_W'(pos % TABLE_DEPTH);
      keep        = (ref_f == meth_b);
    end
  end

  // non-cytosine bases and out-of-range flushes are consumed here
  assign in_ready_o = q_ready_i && !clearing_i;
  assign q_push_o   = in_valid_i && in_ready_o && keep;

endmodule

// ===== rtl/mpt_queue.sv =====
module mpt_queue import mpt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  pop_op_o
);

  op_t               buf_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o  = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = buf_q[rd_q];
  assign do_push  = push_i && ready_o;
  assign do_pop   = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop  ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_q] <= push_op_i;
    end
  end

endmodule

// ===== rtl/mpt_back.sv =====
module mpt_back import mpt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  report_all_i,
  input  logic  q_valid_i,
  input  op_t   q_op_i,
  output logic  q_pop_o,
  output logic  clearing_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output site_t out_site_o
);

  entry_t mem [TABLE_DEPTH];

  back_state_e      state_q, state_d;
  logic [IDX_W-1:0] clr_q, clr_d;
  op_t              op_q;
  entry_t           rd_q;
  logic             out_valid_q, out_valid_d;
  site_t            site_q;

  logic             rd_en;
  logic             we;
  logic [IDX_W-1:0] wa;
  entry_t           wd;
  entry_t           upd;
  logic             hit, emit, go, out_free;

  // slot update and emit decision
  always_comb begin
    hit = rd_q.valid && rd_q.pos == op_q.pos && rd_q.chrom == op_q.chrom &&
          rd_q.minus == op_q.minus;
    emit = rd_q.valid && (rd_q.meth != '0 || rd_q.unmeth != '0) &&
           (report_all_i || rd_q.cpg || rd_q.meth != '0) &&
           (op_q.kind == OP_FLUSH || !hit);
    upd = rd_q;
    if (op_q.kind == OP_FLUSH) begin
      upd.valid = 1'b0;
    end else begin
      if (!hit) begin
        upd.valid  = 1'b1;
        upd.pos    = op_q.pos;
        upd.chrom  = op_q.chrom;
        upd.minus  = op_q.minus;
        upd.cpg    = op_q.cpg;
        upd.meth   = '0;
        upd.unmeth = '0;
      end
      if (op_q.cnt == CNT_METH && upd.meth != CNT_MAX) begin
        upd.meth = upd.meth + 1'b1;
      end else if (op_q.cnt == CNT_UNMETH && upd.unmeth != CNT_MAX) begin
        upd.unmeth = upd.unmeth + 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!emit || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    q_pop_o    = 1'b0;
    rd_en      = 1'b0;
    we         = 1'b0;
    wa         = op_q.idx;
    wd         = upd;
    go         = 1'b0;
    clearing_o = 1'b0;
    clr_d      = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clearing_o = 1'b1;
        we         = 1'b1;
        wa         = clr_q;
        wd         = '0;
        clr_d      = clr_q + 1'b1;
      end
      ST_IDLE: begin
        q_pop_o = q_valid_i;
        rd_en   = q_valid_i;
      end
      ST_EXEC: begin
        go = !emit || out_free;
        we = go;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (go && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      op_q <= q_op_i;
      rd_q <= mem[q_op_i.idx];
    end
    if (we) begin
      mem[wa] <= wd;
    end
    if (go && emit) begin
      site_q.site_position <= rd_q.pos + 32'd1;
      site_q.site_chrom    <= rd_q.chrom;
      site_q.site_minus    <= rd_q.minus;
      site_q.total_count   <= (CNT_W+1)'(rd_q.meth) + (CNT_W+1)'(rd_q.unmeth);
      site_q.meth_count    <= rd_q.meth;
      site_q.is_cpg        <= rd_q.cpg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_site_o  = site_q;

endmodule

// ===== rtl/methylation_pileup_table.sv =====
// Channel   Dir  tuser  tdata
// s_axis    in   cmd    slot, genome_position, chrom_index, read_minus, ref/read/context base
// m_axis    out  -      site_position, site_chrom, site_minus, total_count, meth_count, is_cpg
// cfg       in   -      report_all (write enable, 1-bit data)
//
// In the back end a counted base or flush is a table read followed by an
// update/write of the same slot. Other beats are dropped in the front end.
// After reset all 2048 table slots are cleared in turn; s_axis_tready stays low.
// A 4-entry queue separates front and back; the result register frees the
// back end unless a new site must be reported while the last one still waits.
module methylation_pileup_table import mpt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] cmd
  input  logic        s_axis_tuser,
  // [10:0] slot, [42:11] genome_position, [52:43] chrom_index, [53] read_minus,
  // [61:54] ref_base, [69:62] read_base, [77:70] context_base, [79:78] zero
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] site_position, [41:32] site_chrom, [42] site_minus,
  // [67:43] total_count, [91:68] meth_count, [92] is_cpg, [95:93] zero
  output logic [95:0] m_axis_tdata
);

`include "methylation_pileup_table_defines.svh"

  logic  report_all_q;
  logic  q_push, q_ready, q_valid, q_pop, clearing;
  op_t   push_op, pop_op;
  site_t site;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_all_q <= 1'b0;
    end else if (cfg_we_i) begin
      report_all_q <= cfg_wdata_i;
    end
  end

  mpt_front u_front (
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_data_i  (s_axis_tdata),
    .q_ready_i  (q_ready),
    .clearing_i (clearing),
    .in_ready_o (s_axis_tready),
    .q_push_o   (q_push),
    .q_op_o     (push_op)
  );

  mpt_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .ready_o   (q_ready),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_op_o  (pop_op)
  );

  mpt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .report_all_i (report_all_q),
    .q_valid_i    (q_valid),
    .q_op_i       (pop_op),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_site_o   (site)
  );

  assign m_axis_tdata = {3'b000, site};

  `MPT_ASSERT_NOW(a_no_accept_in_clear, clearing, !s_axis_tready, "beat accepted during table sweep")
  `MPT_ASSERT_NOW(a_no_result_in_clear, clearing, !m_axis_tvalid, "result during table sweep")
  `MPT_ASSERT_NOW(a_queue_empty_after_clear, $fell(clearing), !q_valid, "queue not empty after sweep")
  `MPT_ASSERT_NEXT(a_pop_clears_nothing, q_pop && clearing, 1'b0, "queue popped during sweep")

endmodule
